@@ rtl/aes_pkg.sv @@
// package with aes types, tables and round helper functions
`timescale 1ns / 1ps
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_KEY_HIGH = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KEY_LOW  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_IV_HIGH  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_IV_LOW   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DIR      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEXP,
    ST_RUN,
    ST_DONE
  } aes_state_t;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] sbox_reverse(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input block_t s, input int i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic inv);
    block_t t;
    int src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127 - 8*(4*c + r) -: 8] = inv ? sbox_reverse(get_byte(s, 4*src + r))
                                        : SBOX[get_byte(s, 4*src + r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix(input block_t s, input logic inv);
    block_t t;
    logic [7:0] a0, a1, a2, a3, u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      if (inv) begin
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u;
        a1 = a1 ^ v;
        a2 = a2 ^ u;
        a3 = a3 ^ v;
      end
      u = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ u ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ u ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ u ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ u ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]} ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ rtl/aes_stream_if.sv @@
// valid/ready stream interface with generic payload
`timescale 1ns / 1ps
interface aes_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/aes128_cbc_cipher.sv @@
// aes-128 cbc cipher with iterative round unit and round key memory
// the first block after a key write runs key expansion (ST_KEXP) before its rounds
// one block at a time: rounds run on the single shared round unit, the result is held in ST_DONE
//   until out_ch.ready, and ST_IDLE follows before the next transfer
// the round keys are built one per cycle into an 11 entry register file
// reset: synchronous active low; clears key, iv, direction, chain and key valid
`timescale 1ns / 1ps
module aes128_cbc_cipher (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [aes_pkg::RegIdxW-1:0]  cfg_idx,
  input  logic [63:0]                  cfg_wdata,
  aes_stream_if.sink                   in_ch,
  aes_stream_if.source                 out_ch
);
  import aes_pkg::*;

  aes_state_t state_r, state_nxt;
  logic [127:0] key_r, iv_r, chain_r, st_r, blk_r;
  logic         dir_r, keys_ok_r;
  logic [3:0]   cnt_r;
  logic [127:0] rk_r [11];
  logic [127:0] kexp_r;
  logic [127:0] rk_rd;
  logic [127:0] round_out;

  assign rk_rd = rk_r[cnt_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = keys_ok_r ? ST_RUN : ST_KEXP;
      ST_KEXP: if (cnt_r == 4'(NumRounds)) state_nxt = ST_RUN;
      ST_RUN: begin
        if ((!dir_r && cnt_r == 4'(NumRounds)) || (dir_r && cnt_r == 4'd0))
          state_nxt = ST_DONE;
      end
      ST_DONE: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_DONE);
    out_ch.data = dir_r ? (st_r ^ chain_r) : st_r;
  end

  always_comb begin
    if (!dir_r) begin
      round_out = sub_shift(st_r, 1'b0);
      if (cnt_r != 4'(NumRounds)) round_out = mix(round_out, 1'b0);
      round_out = round_out ^ rk_rd;
    end else begin
      round_out = sub_shift(st_r, 1'b1) ^ rk_rd;
      if (cnt_r != 4'd0) round_out = mix(round_out, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r <= '0;
      iv_r <= '0;
      dir_r <= 1'b0;
      chain_r <= '0;
      keys_ok_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY_HIGH: begin key_r[127:64] <= cfg_wdata; keys_ok_r <= 1'b0; end
          REG_KEY_LOW:  begin key_r[63:0] <= cfg_wdata; keys_ok_r <= 1'b0; end
          REG_IV_HIGH:  iv_r[127:64] <= cfg_wdata;
          REG_IV_LOW:   iv_r[63:0] <= cfg_wdata;
          REG_DIR:      dir_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            blk_r <= in_ch.data[128:1];
            if (in_ch.data[0]) chain_r <= iv_r;
            cnt_r <= keys_ok_r ? (dir_r ? 4'(NumRounds) : 4'd0) : 4'd0;
            kexp_r <= key_r;
          end
        end
        ST_KEXP: begin
          rk_r[cnt_r] <= kexp_r;
          if (cnt_r != 4'(NumRounds)) kexp_r <= next_round_key(kexp_r, RCON[cnt_r]);
          if (cnt_r == 4'(NumRounds)) begin
            keys_ok_r <= 1'b1;
            cnt_r <= dir_r ? 4'(NumRounds) : 4'd0;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_RUN: begin
          if (!dir_r) begin
            if (cnt_r == 4'd0) st_r <= blk_r ^ chain_r ^ rk_rd;
            else st_r <= round_out;
            if (cnt_r == 4'(NumRounds)) chain_r <= round_out;
            else cnt_r <= cnt_r + 4'd1;
          end else begin
            if (cnt_r == 4'(NumRounds)) st_r <= blk_r ^ rk_rd;
            else st_r <= round_out;
            if (cnt_r != 4'd0) cnt_r <= cnt_r - 4'd1;
          end
        end
        ST_DONE: begin
          if (out_ch.ready && dir_r) chain_r <= blk_r;
        end
        default: ;
      endcase
    end
  end
endmodule
